// ----- rtl/u16u8_pkg.sv -----
// ----------------------------------------------------------------------------
// u16u8_pkg
// Shared types, constants and the UTF-8 encoder for the transcoder.
// ----------------------------------------------------------------------------
package u16u8_pkg;

  localparam int QDepth = 4;
  localparam int QAw    = $clog2(QDepth);

  localparam logic [5:0]  HiSurrTag  = 6'b110110;
  localparam logic [5:0]  LoSurrTag  = 6'b110111;
  localparam logic [20:0] SuppBase   = 21'h10000;
  localparam logic [20:0] Lim1Byte   = 21'h00080;
  localparam logic [20:0] Lim2Byte   = 21'h00800;
  localparam logic [20:0] Lim3Byte   = 21'h10000;
  localparam logic [7:0]  Lead2      = 8'hC0;
  localparam logic [7:0]  Lead3      = 8'hE0;
  localparam logic [7:0]  Lead4      = 8'hF0;
  localparam logic [7:0]  ContTag    = 8'h80;

  // One queued run: up to four bytes, byte 0 sent first; last_idx is count - 1.
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      last_idx;
    logic            eot;
  } run_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic run_t encode(input logic [20:0] cp, input logic eot);
    run_t r;
    r.bytes    = '0;
    r.eot      = eot;
    r.last_idx = 2'd0;
    if (cp < Lim1Byte) begin
      r.bytes[0] = cp[7:0];
    end else if (cp < Lim2Byte) begin
      r.bytes[0] = Lead2 | {3'b000, cp[10:6]};
      r.bytes[1] = ContTag | {2'b00, cp[5:0]};
      r.last_idx = 2'd1;
    end else if (cp < Lim3Byte) begin
      r.bytes[0] = Lead3 | {4'b0000, cp[15:12]};
      r.bytes[1] = ContTag | {2'b00, cp[11:6]};
      r.bytes[2] = ContTag | {2'b00, cp[5:0]};
      r.last_idx = 2'd2;
    end else begin
      r.bytes[0] = Lead4 | {5'b00000, cp[20:18]};
      r.bytes[1] = ContTag | {2'b00, cp[17:12]};
      r.bytes[2] = ContTag | {2'b00, cp[11:6]};
      r.bytes[3] = ContTag | {2'b00, cp[5:0]};
      r.last_idx = 2'd3;
    end
    return r;
  endfunction

endpackage

// ----- rtl/u16u8_front.sv -----
// ----------------------------------------------------------------------------
// u16u8_front
// Accepts code units, pairs surrogates and encodes each code point into a run.
// ----------------------------------------------------------------------------
module u16u8_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [15:0]         in_code_unit,
  input  logic                in_last_unit,
  input  u16u8_pkg::q_status_t q_status,
  output logic                push,
  output u16u8_pkg::run_t     push_run
);

  logic       held_valid_r, held_valid_nxt;
  logic [9:0] held_bits_r, held_bits_nxt;
  logic       is_hi, is_lo, xfer;
  logic [20:0] cp;

  assign in_ready = !q_status.full;
  assign xfer     = in_valid && in_ready;
  assign is_hi    = (in_code_unit[15:10] == u16u8_pkg::HiSurrTag);
  assign is_lo    = (in_code_unit[15:10] == u16u8_pkg::LoSurrTag);

  always_comb begin
    held_valid_nxt = held_valid_r;
    held_bits_nxt  = held_bits_r;
    push           = 1'b0;
    cp             = {5'd0, in_code_unit};
    if (xfer) begin
      held_valid_nxt = 1'b0;
      held_bits_nxt  = '0;
      if (held_valid_r && is_lo) begin
        cp   = u16u8_pkg::SuppBase + {1'b0, held_bits_r, in_code_unit[9:0]};
        push = 1'b1;
      end else if (is_hi) begin
        if (!in_last_unit) begin
          held_valid_nxt = 1'b1;
          held_bits_nxt  = in_code_unit[9:0];
        end
      end else if (!is_lo) begin
        push = 1'b1;
      end
    end
  end

  assign push_run = u16u8_pkg::encode(cp, in_last_unit);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_valid_r <= 1'b0;
      held_bits_r  <= '0;
    end else begin
      held_valid_r <= held_valid_nxt;
      held_bits_r  <= held_bits_nxt;
    end
  end

endmodule

// ----- rtl/u16u8_queue.sv -----
// ----------------------------------------------------------------------------
// u16u8_queue
// Small FIFO of encoded runs between the front and back ends.
// ----------------------------------------------------------------------------
module u16u8_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  u16u8_pkg::run_t      push_run,
  input  logic                 pop,
  output u16u8_pkg::run_t      head_run,
  output u16u8_pkg::q_status_t status
);

  localparam int Aw = u16u8_pkg::QAw;

  u16u8_pkg::run_t        mem_r [u16u8_pkg::QDepth];
  logic [Aw-1:0]          wr_ptr_r, wr_ptr_nxt;
  logic [Aw-1:0]          rd_ptr_r, rd_ptr_nxt;
  logic [Aw:0]            count_r, count_nxt;

  assign status.full  = (count_r == (Aw+1)'(u16u8_pkg::QDepth));
  assign status.empty = (count_r == '0);
  assign head_run     = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) count_nxt = count_r + 1'b1;
    else if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_run;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!status.full || pop))
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !status.empty)
    else $error("queue pop while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (Aw+1)'(u16u8_pkg::QDepth))
    else $error("queue count out of range");
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue count did not advance");
`endif

endmodule

// ----- rtl/u16u8_back.sv -----
// ----------------------------------------------------------------------------
// u16u8_back
// Pulls runs from the queue and sends them out one byte per transfer.
// ----------------------------------------------------------------------------
module u16u8_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  u16u8_pkg::run_t      head_run,
  input  u16u8_pkg::q_status_t q_status,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_byte,
  output logic                 out_last_of_run,
  output logic                 out_end_of_text
);

  u16u8_pkg::run_t cur_r, cur_nxt;
  logic            cur_valid_r, cur_valid_nxt;
  logic [1:0]      idx_r, idx_nxt;
  logic            at_last, xfer, load;

  assign at_last = (idx_r == cur_r.last_idx);
  assign xfer    = cur_valid_r && out_ready;
  assign load    = !cur_valid_r || (xfer && at_last);
  assign pop     = load && !q_status.empty;

  always_comb begin
    cur_nxt       = cur_r;
    cur_valid_nxt = cur_valid_r;
    idx_nxt       = idx_r;
    if (load) begin
      cur_nxt       = head_run;
      cur_valid_nxt = !q_status.empty;
      idx_nxt       = 2'd0;
    end else if (xfer) begin
      idx_nxt = idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      idx_r       <= 2'd0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

  assign out_valid       = cur_valid_r;
  assign out_byte        = cur_r.bytes[idx_r];
  assign out_last_of_run = at_last;
  assign out_end_of_text = cur_r.eot;

`ifndef SYNTH
  a_idx_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    cur_valid_r |-> (idx_r <= cur_r.last_idx))
    else $error("byte index past end of run");
  a_no_pop_midrun: assert property (@(posedge clk) disable iff (!rst_n)
    (cur_valid_r && !at_last) |-> !pop)
    else $error("run fetched before current run finished");
  a_stall_holds_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (cur_valid_r && !out_ready) |=> $stable(idx_r))
    else $error("byte index moved during stall");
`endif

endmodule

// ----- rtl/utf16_to_utf8_transcoder.sv -----
// ----------------------------------------------------------------------------
// utf16_to_utf8_transcoder
// UTF-16 code units in, UTF-8 bytes out, surrogate pairs combined.
// ----------------------------------------------------------------------------
// A code unit transfer is taken every cycle while the four-run queue has room;
// the front end encodes it in the same cycle. The back end sends one byte per
// cycle while the receiver is ready and runs are queued; an item yields 1 to 4
// bytes (its UTF-8 length), lone or dropped surrogates none. out_last_of_run marks the final byte
// of an item, out_end_of_text repeats the item's last-unit flag.
module utf16_to_utf8_transcoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_code_unit,
  input  logic        in_last_unit,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_last_of_run,
  output logic        out_end_of_text
);

  u16u8_pkg::run_t      push_run, head_run;
  u16u8_pkg::q_status_t q_status;
  logic                 push, pop;

  u16u8_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_code_unit (in_code_unit),
    .in_last_unit (in_last_unit),
    .q_status     (q_status),
    .push         (push),
    .push_run     (push_run)
  );

  u16u8_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_run (push_run),
    .pop      (pop),
    .head_run (head_run),
    .status   (q_status)
  );

  u16u8_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_run        (head_run),
    .q_status        (q_status),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_last_of_run (out_last_of_run),
    .out_end_of_text (out_end_of_text)
  );

endmodule

// ----- tb/sv/utf16_to_utf8_transcoder_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf16_to_utf8_transcoder_tb
// Self-checking bench: UTF-16 code units in, UTF-8 byte stream checked.
// ----------------------------------------------------------------------------
// A queue of code units is filled per phase: directed edge cases first
// (encoding boundaries, surrogate pairs, lone and dropped surrogates, the
// last-unit flag), then random text that is mostly well-formed. A negedge
// driver presents the units, a posedge monitor predicts the bytes of each
// accepted unit and checks every byte transfer in order. Phases vary the
// sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module utf16_to_utf8_transcoder_tb;

  localparam int          HalfPeriod  = 6;
  localparam int          StallLimit  = 2000;
  localparam int          RandPerPhase = 14;
  localparam logic [15:0] HighFirst   = 16'hD800;
  localparam logic [15:0] HighLast    = 16'hDBFF;
  localparam logic [15:0] LowFirst    = 16'hDC00;
  localparam logic [15:0] LowLast     = 16'hDFFF;

  typedef struct {
    logic [15:0] unit;
    logic        last;
  } code_unit_t;

  typedef struct {
    logic [7:0] data;
    logic       last_of_run;
    logic       end_of_text;
  } utf8_byte_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [15:0] in_code_unit;
  logic        in_last_unit;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_byte;
  logic        out_last_of_run;
  logic        out_end_of_text;

  code_unit_t  unit_q[$];
  utf8_byte_t  utf8_q[$];
  code_unit_t  next_unit;
  utf8_byte_t  want;

  logic [9:0]  held_bits;
  logic        holding;
  logic        in_taken;
  int          send_idle_pct;
  int          recv_stall_pct;
  int          n_errors;
  int          n_units;
  int          n_bytes;
  int          idle_cycles;
  int          n_phases;

  utf16_to_utf8_transcoder dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_code_unit   (in_code_unit),
    .in_last_unit   (in_last_unit),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_last_of_run(out_last_of_run),
    .out_end_of_text(out_end_of_text)
  );

  always #HalfPeriod clk = ~clk;

  function automatic logic is_high(input logic [15:0] u);
    return u >= HighFirst && u <= HighLast;
  endfunction

  function automatic logic is_low(input logic [15:0] u);
    return u >= LowFirst && u <= LowLast;
  endfunction

  task automatic emit_code_point(input logic [20:0] cp, input logic eot);
    logic [7:0] b [4];
    int         n;
    utf8_byte_t e;
    if (cp < 21'h80) begin
      b[0] = cp[7:0];
      n = 1;
    end else if (cp < 21'h800) begin
      b[0] = 8'hC0 | {3'b000, cp[10:6]};
      b[1] = 8'h80 | {2'b00, cp[5:0]};
      n = 2;
    end else if (cp < 21'h10000) begin
      b[0] = 8'hE0 | {4'b0000, cp[15:12]};
      b[1] = 8'h80 | {2'b00, cp[11:6]};
      b[2] = 8'h80 | {2'b00, cp[5:0]};
      n = 3;
    end else begin
      b[0] = 8'hF0 | {5'b00000, cp[20:18]};
      b[1] = 8'h80 | {2'b00, cp[17:12]};
      b[2] = 8'h80 | {2'b00, cp[11:6]};
      b[3] = 8'h80 | {2'b00, cp[5:0]};
      n = 4;
    end
    for (int k = 0; k < n; k++) begin
      e.data        = b[k];
      e.last_of_run = (k == n - 1);
      e.end_of_text = eot;
      utf8_q = {utf8_q, e};
    end
  endtask

  task automatic transcode_unit(input logic [15:0] unit, input logic last);
    logic [20:0] cp;
    if (holding && is_low(unit)) begin
      cp = 21'h10000 + {1'b0, held_bits, unit[9:0]};
      holding   = 1'b0;
      held_bits = '0;
      emit_code_point(cp, last);
    end else begin
      holding   = 1'b0;
      held_bits = '0;
      if (is_high(unit)) begin
        if (!last) begin
          held_bits = unit[9:0];
          holding   = 1'b1;
        end
      end else if (!is_low(unit)) begin
        emit_code_point({5'b00000, unit}, last);
      end
    end
    if (last) begin
      holding   = 1'b0;
      held_bits = '0;
    end
  endtask

  task automatic queue_unit(input logic [15:0] unit, input logic last);
    code_unit_t c;
    c.unit = unit;
    c.last = last;
    unit_q = {unit_q, c};
  endtask

  task automatic queue_directed();
    queue_unit(16'h0000, 1'b0);
    queue_unit(16'h007F, 1'b0);
    queue_unit(16'h0080, 1'b0);
    queue_unit(16'h07FF, 1'b0);
    queue_unit(16'h0800, 1'b0);
    queue_unit(16'hD7FF, 1'b0);
    queue_unit(16'hE000, 1'b0);
    queue_unit(16'hFFFF, 1'b1);
    queue_unit(16'hD800, 1'b0);
    queue_unit(16'hDC00, 1'b0);
    queue_unit(16'hDBFF, 1'b0);
    queue_unit(16'hDFFF, 1'b0);
    queue_unit(16'hDC00, 1'b0);   // lone low
    queue_unit(16'hDFFF, 1'b0);
    queue_unit(16'hD800, 1'b0);   // held high dropped by a plain unit
    queue_unit(16'h0041, 1'b0);
    queue_unit(16'hDABC, 1'b0);   // high replaced by another high
    queue_unit(16'hDBFF, 1'b0);
    queue_unit(16'hDC12, 1'b0);
    queue_unit(16'hDBFF, 1'b1);   // high on the last unit
    queue_unit(16'hDC00, 1'b0);   // must stand alone after end of text
    queue_unit(16'hD83D, 1'b0);   // pair finished on the last unit
    queue_unit(16'hDE00, 1'b1);
    queue_unit(16'h5555, 1'b0);
    queue_unit(16'hAAAA, 1'b1);
  endtask

  task automatic queue_random(input int count);
    int          sel;
    logic [15:0] u;
    logic        l;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(99);
      l = ($urandom_range(15) == 0);
      if (sel < 20) begin
        queue_unit(16'($urandom_range(16'h007F)), l);
      end else if (sel < 35) begin
        queue_unit(16'($urandom_range(16'h07FF, 16'h0080)), l);
      end else if (sel < 55) begin
        if ($urandom_range(1))
          u = 16'($urandom_range(16'hD7FF, 16'h0800));
        else
          u = 16'($urandom_range(16'hFFFF, 16'hE000));
        queue_unit(u, l);
      end else if (sel < 80) begin
        queue_unit(HighFirst | 16'($urandom_range(10'h3FF)), ($urandom_range(31) == 0));
        queue_unit(LowFirst | 16'($urandom_range(10'h3FF)), l);
      end else if (sel < 87) begin
        queue_unit(HighFirst | 16'($urandom_range(10'h3FF)), 1'b0);
        queue_unit(16'($urandom_range(16'hFFFF)), l);
      end else if (sel < 93) begin
        queue_unit(LowFirst | 16'($urandom_range(10'h3FF)), l);
      end else begin
        queue_unit(16'($urandom_range(16'hFFFF)), l);
      end
    end
  endtask

  task automatic drain();
    while (unit_q.size() > 0 || in_valid || utf8_q.size() > 0) @(posedge clk);
  endtask

  // driver
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_taken) begin
        if (unit_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          next_unit = unit_q.pop_front();
          in_valid     <= 1'b1;
          in_code_unit <= next_unit.unit;
          in_last_unit <= next_unit.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    if (rst_n) begin
      in_taken <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        transcode_unit(in_code_unit, in_last_unit);
        n_units++;
      end
      if (out_valid && out_ready) begin
        n_bytes++;
        if (utf8_q.size() == 0) begin
          $error("unexpected byte transfer: out_byte=%02h", out_byte);
          n_errors++;
        end else begin
          want = utf8_q.pop_front();
          if (out_byte !== want.data) begin
            $error("out_byte: expected %02h, actual %02h", want.data, out_byte);
            n_errors++;
          end
          if (out_last_of_run !== want.last_of_run) begin
            $error("out_last_of_run: expected %0b, actual %0b",
                   want.last_of_run, out_last_of_run);
            n_errors++;
          end
          if (out_end_of_text !== want.end_of_text) begin
            $error("out_end_of_text: expected %0b, actual %0b",
                   want.end_of_text, out_end_of_text);
            n_errors++;
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst_n && (in_valid || unit_q.size() > 0 || utf8_q.size() > 0) &&
        !(in_valid && in_ready) && !(out_valid && out_ready))
      idle_cycles++;
    else
      idle_cycles = 0;
    if (idle_cycles >= StallLimit) begin
      $display("Timeout: no transfer for %0d cycles", StallLimit);
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    clk            = 1'b0;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_code_unit   = '0;
    in_last_unit   = 1'b0;
    out_ready      = 1'b0;
    in_taken       = 1'b0;
    held_bits      = '0;
    holding        = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    n_errors       = 0;
    n_units        = 0;
    n_bytes        = 0;
    idle_cycles    = 0;
    n_phases       = 0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
          queue_directed();
        end
        1: begin
          send_idle_pct  = 52;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 52;
        end
        default: begin
          send_idle_pct  = 26;
          recv_stall_pct = 26;
        end
      endcase
      queue_random(RandPerPhase);
      drain();
      n_phases++;
    end

    repeat (20) @(posedge clk);
    $display("Summary: %0d code units in %0d idle/stall phases, %0d UTF-8 bytes checked",
             n_units, n_phases, n_bytes);
    $display("Surrogate pairs, lone surrogates and end-of-text flags included; %0d errors",
             n_errors);
    if (n_errors == 0 && utf8_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      if (utf8_q.size() != 0)
        $error("%0d expected bytes never arrived", utf8_q.size());
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
